// ===== design/pdro_pkg.sv =====
`default_nettype none

package pdro_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int GAIN_W      = 16;
   localparam int BOUND_W     = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_FWD_POS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_FWD_NEG     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_CREEP_BACK  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_FWD_OUTSIDE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_BAND_LOW     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_BAND_HIGH    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAT_BAND_LOW     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAT_BAND_HIGH    = 3'd7;

   localparam logic [GAIN_W-1:0]  RST_GAIN_FWD_POS     = 16'd7455;
   localparam logic [GAIN_W-1:0]  RST_GAIN_FWD_NEG     = 16'd10650;
   localparam logic [GAIN_W-1:0]  RST_GAIN_CREEP_BACK  = 16'd32768;
   localparam logic [GAIN_W-1:0]  RST_GAIN_FWD_OUTSIDE = 16'd13926;
   localparam logic [BOUND_W-1:0] RST_FWD_BAND_LOW     = 15'd410;
   localparam logic [BOUND_W-1:0] RST_FWD_BAND_HIGH    = 15'd12288;
   localparam logic [BOUND_W-1:0] RST_LAT_BAND_LOW     = 15'd205;
   localparam logic [BOUND_W-1:0] RST_LAT_BAND_HIGH    = 15'd4506;

   // backward creep limit, -0.05 m/s
   localparam logic signed [15:0] CREEP_LIMIT = 16'sd205;

   // cordic
   localparam int CORDIC_ITERS_DEFAULT = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int ITER_W  = 5;
   localparam int ATAN_W  = 30;
   localparam int ANGLE_W = 36;
   localparam int XY_W    = 34;
   localparam logic signed [ANGLE_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [XY_W-1:0]    CORDIC_K_Q30 = 34'sd652032874;

   // shared multiplier
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int PSUM_W  = 51;
   localparam int W_W     = 26;

   // time scaling: (mag*dt + 8e6) / 16e6 done as a shift by 9 and a divide by 31250
   localparam int TPROD_W   = 58;
   localparam logic [TPROD_W:0] TIME_BIAS = 59'd8000000;
   localparam int DIV_SHIFT = 9;
   localparam int DQ_W      = TPROD_W + 1 - DIV_SHIFT;
   localparam int DIV_REM_W = 15;
   localparam int DIV_STEPS = DQ_W / 2;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_REM_W+1:0] DIV_D1 = 17'd31250;
   localparam logic [DIV_REM_W+1:0] DIV_D2 = 17'd62500;
   localparam logic [DIV_REM_W+1:0] DIV_D3 = 17'd93750;
   localparam int QUOT_W  = 35;
   localparam int DELTA_W = QUOT_W + 1;
   localparam int POS_W   = 48;

   typedef struct packed {
      logic signed [15:0] vel_forward;
      logic signed [15:0] vel_lateral;
      logic signed [15:0] yaw_raw;
      logic [31:0]        time_us;
   } req_payload_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [15:0]      heading;
      logic signed [15:0]      vel_forward_corrected;
      logic signed [15:0]      vel_lateral_gated;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIV_REM_W-1:0] rem;
      logic [DQ_W-1:0]      dq;
   } div_lane_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_CORDIC,
      ST_FLIP,
      ST_MXC,
      ST_MLS,
      ST_MLC,
      ST_MFS,
      ST_MDX,
      ST_MDY,
      ST_LDY,
      ST_DIV,
      ST_ACC,
      ST_PUT
   } state_type;

   function automatic logic [ATAN_W-1:0] atan_q30(input logic [ITER_W-1:0] idx);
      logic [ATAN_W-1:0] r;
      case (idx)
         5'd0:    r = 30'd843314856;
         5'd1:    r = 30'd497837829;
         5'd2:    r = 30'd263043836;
         5'd3:    r = 30'd133525158;
         5'd4:    r = 30'd67021686;
         5'd5:    r = 30'd33543515;
         5'd6:    r = 30'd16775850;
         5'd7:    r = 30'd8388437;
         5'd8:    r = 30'd4194282;
         5'd9:    r = 30'd2097149;
         5'd10:   r = 30'd1048575;
         5'd11:   r = 30'd524287;
         5'd12:   r = 30'd262143;
         5'd13:   r = 30'd131071;
         5'd14:   r = 30'd65535;
         5'd15:   r = 30'd32767;
         5'd16:   r = 30'd16383;
         5'd17:   r = 30'd8191;
         5'd18:   r = 30'd4095;
         5'd19:   r = 30'd2047;
         5'd20:   r = 30'd1023;
         5'd21:   r = 30'd511;
         5'd22:   r = 30'd255;
         5'd23:   r = 30'd127;
         default: r = '0;
      endcase
      return r;
   endfunction

   // one radix-4 restoring step of the divide by 31250
   function automatic div_lane_type div_step(input div_lane_type cur);
      logic [DIV_REM_W+1:0] t;
      logic [DIV_REM_W+1:0] sub;
      logic [1:0]           q;
      div_lane_type         nxt;
      t = {cur.rem, cur.dq[DQ_W-1 -: 2]};
      if (t >= DIV_D3) begin
         q = 2'd3;
         sub = DIV_D3;
      end else if (t >= DIV_D2) begin
         q = 2'd2;
         sub = DIV_D2;
      end else if (t >= DIV_D1) begin
         q = 2'd1;
         sub = DIV_D1;
      end else begin
         q = 2'd0;
         sub = '0;
      end
      nxt.rem = DIV_REM_W'(t - sub);
      nxt.dq  = {cur.dq[DQ_W-3:0], q};
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ===== design/planar_dead_reckoning_odometry_unit.sv =====
`default_nettype none

// Planar dead-reckoning odometry. Each req beat carries forward and lateral body speed (Q4.12
// m/s), raw yaw (Q4.12 rad) and a microsecond timestamp; each produces exactly one rsp beat with
// the saturating 48-bit X/Y position (2^-16 m), the heading (reference yaw minus raw yaw, the
// reference being the first nonzero yaw seen), the calibrated forward speed and the band-gated
// lateral speed. Elapsed time is measured from the previous beat, from time 0 after reset.
// The user must write gains and bands on the csr port only while the block is idle; the block
// itself does not enforce this. A beat holds the block from accept to the next possible accept:
// one iteration per cycle of the shared cordic stage, seven passes through the single
// 34x33 multiplier, and 25 radix-4 steps of the divide by 31250 that scales both axes at once.
// req_stall is high while a beat is in work; a finished rsp beat waits in its output register
// and does not hold off the next req beat.
module planar_dead_reckoning_odometry_unit #(
   parameter int CORDIC_ITERS = pdro_pkg::CORDIC_ITERS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire pdro_pkg::req_payload_type        req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output pdro_pkg::rsp_payload_type             rsp_payload,
   input  wire logic                             csr_we,
   input  wire logic [pdro_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pdro_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pdro_pkg::*;

   // iterations beyond the atan table are dropped
   localparam int ITERS_EFF = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;
   localparam logic [ITER_W-1:0]    ITER_LAST = ITER_W'(ITERS_EFF - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_STEPS - 1);
   localparam logic signed [PSUM_W-1:0] RND22 = 51'sd2097152;
   localparam logic signed [33:0]       RND13 = 34'sd4096;

   // configuration registers
   logic [GAIN_W-1:0]  gain_fwd_pos_ff, gain_fwd_pos_in;
   logic [GAIN_W-1:0]  gain_fwd_neg_ff, gain_fwd_neg_in;
   logic [GAIN_W-1:0]  gain_creep_back_ff, gain_creep_back_in;
   logic [GAIN_W-1:0]  gain_fwd_outside_ff, gain_fwd_outside_in;
   logic [BOUND_W-1:0] fwd_band_low_ff, fwd_band_low_in;
   logic [BOUND_W-1:0] fwd_band_high_ff, fwd_band_high_in;
   logic [BOUND_W-1:0] lat_band_low_ff, lat_band_low_in;
   logic [BOUND_W-1:0] lat_band_high_ff, lat_band_high_in;

   // sequencer and architectural state
   state_type                state_ff, state_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic signed [POS_W-1:0]  x_accum_ff, x_accum_in;
   logic signed [POS_W-1:0]  y_accum_ff, y_accum_in;
   logic signed [15:0]       yaw_ref_ff, yaw_ref_in;
   logic                     ref_pending_ff, ref_pending_in;
   logic [31:0]              last_time_ff, last_time_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   // working registers of the beat in progress
   logic signed [15:0]       vf_ff, vf_in;
   logic signed [15:0]       vlg_ff, vlg_in;
   logic signed [15:0]       vfc_ff, vfc_in;
   logic signed [15:0]       heading_ff, heading_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [31:0]              dt_ff, dt_in;
   logic signed [ANGLE_W-1:0] ang_ff, ang_in;
   logic signed [XY_W-1:0]   x_ff, x_in;
   logic signed [XY_W-1:0]   y_ff, y_in;
   logic                     flip_ff, flip_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PSUM_W-1:0] acc_ff, acc_in;
   logic signed [W_W-1:0]    wx_ff, wx_in;
   logic signed [W_W-1:0]    wy_ff, wy_in;
   div_lane_type             lane_x_ff, lane_x_in;
   div_lane_type             lane_y_ff, lane_y_in;

   // control
   logic                      req_accept;
   logic                      slot_free;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;

   // accept-cycle front end
   logic                yaw_latch;
   logic signed [15:0]  ref_new;
   logic signed [16:0]  hdiff;
   logic signed [15:0]  heading_sat;
   logic [15:0]         fmag;
   logic [15:0]         lmag;
   logic                fwd_inside;
   logic                fwd_creep;
   logic [GAIN_W-1:0]   gain_sel;
   logic                lat_inside;

   // gain-state angle reduction
   logic signed [ANGLE_W-1:0] ang0, ang1, ang2;

   // cordic step
   logic signed [XY_W-1:0]    x_shr, y_shr;
   logic signed [ANGLE_W-1:0] atan_ext;

   // product rounding
   logic signed [33:0]       vfc_sum;
   logic signed [20:0]       vfc_shr;
   logic signed [15:0]       vfc_sat;
   logic signed [PSUM_W-1:0] wsum;
   logic [W_W-1:0]           wx_mag, wy_mag;
   logic [TPROD_W:0]         tnum;

   // accumulate
   logic signed [DELTA_W-1:0] dx, dy;
   logic signed [POS_W:0]     sum_x, sum_y;

   assign req_accept  = req_valid && !req_stall;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // csr writes
   always_comb begin
      gain_fwd_pos_in     = gain_fwd_pos_ff;
      gain_fwd_neg_in     = gain_fwd_neg_ff;
      gain_creep_back_in  = gain_creep_back_ff;
      gain_fwd_outside_in = gain_fwd_outside_ff;
      fwd_band_low_in     = fwd_band_low_ff;
      fwd_band_high_in    = fwd_band_high_ff;
      lat_band_low_in     = lat_band_low_ff;
      lat_band_high_in    = lat_band_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN_FWD_POS:     gain_fwd_pos_in     = csr_wdata;
            CSR_GAIN_FWD_NEG:     gain_fwd_neg_in     = csr_wdata;
            CSR_GAIN_CREEP_BACK:  gain_creep_back_in  = csr_wdata;
            CSR_GAIN_FWD_OUTSIDE: gain_fwd_outside_in = csr_wdata;
            CSR_FWD_BAND_LOW:     fwd_band_low_in     = csr_wdata[BOUND_W-1:0];
            CSR_FWD_BAND_HIGH:    fwd_band_high_in    = csr_wdata[BOUND_W-1:0];
            CSR_LAT_BAND_LOW:     lat_band_low_in     = csr_wdata[BOUND_W-1:0];
            CSR_LAT_BAND_HIGH:    lat_band_high_in    = csr_wdata[BOUND_W-1:0];
            default: ;
         endcase
      end
   end

   // front end on the accepted beat: reference latch, heading, gain pick, lateral gate
   always_comb begin
      yaw_latch = ref_pending_ff && (req_payload.yaw_raw != 16'sd0);
      ref_new   = yaw_latch ? req_payload.yaw_raw : yaw_ref_ff;
      hdiff     = {ref_new[15], ref_new} - {req_payload.yaw_raw[15], req_payload.yaw_raw};
      if (hdiff[16] != hdiff[15]) begin
         heading_sat = hdiff[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         heading_sat = hdiff[15:0];
      end

      // magnitude of -32768 is 32768, which still fits 16 unsigned bits
      fmag = req_payload.vel_forward[15] ? (~req_payload.vel_forward + 16'd1)
                                         : req_payload.vel_forward;
      lmag = req_payload.vel_lateral[15] ? (~req_payload.vel_lateral + 16'd1)
                                         : req_payload.vel_lateral;
      fwd_inside = (fmag > {1'b0, fwd_band_low_ff}) && (fmag < {1'b0, fwd_band_high_ff});
      fwd_creep  = req_payload.vel_forward[15] && (req_payload.vel_forward > -CREEP_LIMIT);
      if (fwd_inside) begin
         gain_sel = req_payload.vel_forward[15] ? gain_fwd_neg_ff : gain_fwd_pos_ff;
      end else if (fwd_creep) begin
         gain_sel = gain_creep_back_ff;
      end else begin
         gain_sel = gain_fwd_outside_ff;
      end
      lat_inside = (lmag > {1'b0, lat_band_low_ff}) && (lmag < {1'b0, lat_band_high_ff});
   end

   // angle to q.30, wrap into [-pi, pi]; the fold into [-pi/2, pi/2] follows in ST_GAIN
   always_comb begin
      ang0 = {{2{heading_ff[15]}}, heading_ff, 18'b0};
      ang1 = (ang0 > PI_Q30) ? ang0 - TWO_PI_Q30 : ang0;
      ang2 = (ang1 < -PI_Q30) ? ang1 + TWO_PI_Q30 : ang1;
   end

   // shared cordic stage
   assign x_shr    = x_ff >>> iter_ff;
   assign y_shr    = y_ff >>> iter_ff;
   assign atan_ext = {{(ANGLE_W-ATAN_W){1'b0}}, atan_q30(iter_ff)};

   // rounding of the gain product, half up, then saturate
   always_comb begin
      vfc_sum = $signed(prod_ff[33:0]) + RND13;
      vfc_shr = vfc_sum[33:13];
      if (!vfc_shr[20] && (|vfc_shr[19:15])) begin
         vfc_sat = 16'sh7fff;
      end else if (vfc_shr[20] && !(&vfc_shr[19:15])) begin
         vfc_sat = 16'sh8000;
      end else begin
         vfc_sat = vfc_shr[15:0];
      end
   end

   // rotated speed sums; in MLC the second product is added, in MDX subtracted
   assign wsum = (state_ff == ST_MLC) ? acc_ff + $signed(prod_ff[PSUM_W-1:0]) + RND22
                                      : acc_ff - $signed(prod_ff[PSUM_W-1:0]) + RND22;
   assign wx_mag = wx_ff[W_W-1] ? (~wx_ff + W_W'(1)) : wx_ff;
   assign wy_mag = wy_ff[W_W-1] ? (~wy_ff + W_W'(1)) : wy_ff;
   assign tnum   = {1'b0, prod_ff[TPROD_W-1:0]} + TIME_BIAS;

   // deltas, rounded half away from zero by sign-magnitude
   always_comb begin
      dx = wx_ff[W_W-1] ? -$signed({1'b0, lane_x_ff.dq[QUOT_W-1:0]})
                        :  $signed({1'b0, lane_x_ff.dq[QUOT_W-1:0]});
      dy = wy_ff[W_W-1] ? -$signed({1'b0, lane_y_ff.dq[QUOT_W-1:0]})
                        :  $signed({1'b0, lane_y_ff.dq[QUOT_W-1:0]});
      sum_x = {x_accum_ff[POS_W-1], x_accum_ff} + {{(POS_W+1-DELTA_W){dx[DELTA_W-1]}}, dx};
      sum_y = {y_accum_ff[POS_W-1], y_accum_ff} + {{(POS_W+1-DELTA_W){dy[DELTA_W-1]}}, dy};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_CORDIC;
         ST_CORDIC: if (iter_ff == ITER_LAST) state_in = ST_FLIP;
         ST_FLIP:   state_in = ST_MXC;
         ST_MXC:    state_in = ST_MLS;
         ST_MLS:    state_in = ST_MLC;
         ST_MLC:    state_in = ST_MFS;
         ST_MFS:    state_in = ST_MDX;
         ST_MDX:    state_in = ST_MDY;
         ST_MDY:    state_in = ST_LDY;
         ST_LDY:    state_in = ST_DIV;
         ST_DIV:    if (div_cnt_ff == DIV_LAST) state_in = ST_ACC;
         ST_ACC:    state_in = ST_PUT;
         ST_PUT:    if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: stall and multiplier operand select
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_GAIN: begin
            mul_a = {{(MUL_A_W-16){vf_ff[15]}}, vf_ff};
            mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, gain_ff};
         end
         ST_MXC: begin
            mul_a = x_ff;
            mul_b = {{(MUL_B_W-16){vfc_ff[15]}}, vfc_ff};
         end
         ST_MLS: begin
            mul_a = y_ff;
            mul_b = {{(MUL_B_W-16){vlg_ff[15]}}, vlg_ff};
         end
         ST_MLC: begin
            mul_a = x_ff;
            mul_b = {{(MUL_B_W-16){vlg_ff[15]}}, vlg_ff};
         end
         ST_MFS: begin
            mul_a = y_ff;
            mul_b = {{(MUL_B_W-16){vfc_ff[15]}}, vfc_ff};
         end
         ST_MDX: begin
            mul_a = {{(MUL_A_W-W_W){1'b0}}, wx_mag};
            mul_b = {1'b0, dt_ff};
         end
         ST_MDY: begin
            mul_a = {{(MUL_A_W-W_W){1'b0}}, wy_mag};
            mul_b = {1'b0, dt_ff};
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      iter_in        = iter_ff;
      div_cnt_in     = div_cnt_ff;
      x_accum_in     = x_accum_ff;
      y_accum_in     = y_accum_ff;
      yaw_ref_in     = yaw_ref_ff;
      ref_pending_in = ref_pending_ff;
      last_time_in   = last_time_ff;
      rsp_payload_in = rsp_payload_ff;
      vf_in          = vf_ff;
      vlg_in         = vlg_ff;
      vfc_in         = vfc_ff;
      heading_in     = heading_ff;
      gain_in        = gain_ff;
      dt_in          = dt_ff;
      ang_in         = ang_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      flip_in        = flip_ff;
      prod_in        = mul_a * mul_b;
      acc_in         = acc_ff;
      wx_in          = wx_ff;
      wy_in          = wy_ff;
      lane_x_in      = lane_x_ff;
      lane_y_in      = lane_y_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               yaw_ref_in = ref_new;
               if (yaw_latch) ref_pending_in = 1'b0;
               heading_in   = heading_sat;
               vf_in        = req_payload.vel_forward;
               vlg_in       = lat_inside ? req_payload.vel_lateral : 16'sd0;
               gain_in      = gain_sel;
               dt_in        = req_payload.time_us - last_time_ff;
               last_time_in = req_payload.time_us;
            end
         end
         ST_GAIN: begin
            // multiplier takes vf*gain; cordic starts on the folded angle
            x_in    = CORDIC_K_Q30;
            y_in    = '0;
            iter_in = '0;
            if (ang2 > HALF_PI_Q30) begin
               ang_in  = ang2 - PI_Q30;
               flip_in = 1'b1;
            end else if (ang2 < -HALF_PI_Q30) begin
               ang_in  = ang2 + PI_Q30;
               flip_in = 1'b1;
            end else begin
               ang_in  = ang2;
               flip_in = 1'b0;
            end
         end
         ST_CORDIC: begin
            prod_in = prod_ff;
            if (!ang_ff[ANGLE_W-1]) begin
               x_in   = x_ff - y_shr;
               y_in   = y_ff + x_shr;
               ang_in = ang_ff - atan_ext;
            end else begin
               x_in   = x_ff + y_shr;
               y_in   = y_ff - x_shr;
               ang_in = ang_ff + atan_ext;
            end
            iter_in = iter_ff + ITER_W'(1);
         end
         ST_FLIP: begin
            vfc_in = vfc_sat;
            if (flip_ff) begin
               x_in = -x_ff;
               y_in = -y_ff;
            end
         end
         ST_MLS: acc_in = prod_ff[PSUM_W-1:0];
         ST_MLC: wx_in = wsum[W_W+21:22];
         ST_MFS: acc_in = prod_ff[PSUM_W-1:0];
         ST_MDX: wy_in = wsum[W_W+21:22];
         ST_MDY: begin
            lane_x_in.rem = '0;
            lane_x_in.dq  = tnum[TPROD_W:DIV_SHIFT];
         end
         ST_LDY: begin
            lane_y_in.rem = '0;
            lane_y_in.dq  = tnum[TPROD_W:DIV_SHIFT];
            div_cnt_in    = '0;
         end
         ST_DIV: begin
            lane_x_in  = div_step(lane_x_ff);
            lane_y_in  = div_step(lane_y_ff);
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_ACC: begin
            // saturate when the 49-bit sum leaves the 48-bit range
            if (sum_x[POS_W] != sum_x[POS_W-1]) begin
               x_accum_in = {sum_x[POS_W], {(POS_W-1){!sum_x[POS_W]}}};
            end else begin
               x_accum_in = sum_x[POS_W-1:0];
            end
            if (sum_y[POS_W] != sum_y[POS_W-1]) begin
               y_accum_in = {sum_y[POS_W], {(POS_W-1){!sum_y[POS_W]}}};
            end else begin
               y_accum_in = sum_y[POS_W-1:0];
            end
         end
         ST_PUT: begin
            if (slot_free) begin
               rsp_valid_in                         = 1'b1;
               rsp_payload_in.pos_x                 = x_accum_ff;
               rsp_payload_in.pos_y                 = y_accum_ff;
               rsp_payload_in.heading               = heading_ff;
               rsp_payload_in.vel_forward_corrected = vfc_ff;
               rsp_payload_in.vel_lateral_gated     = vlg_ff;
            end
         end
         default: ;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         rsp_valid_ff        <= 1'b0;
         x_accum_ff          <= '0;
         y_accum_ff          <= '0;
         yaw_ref_ff          <= '0;
         ref_pending_ff      <= 1'b1;
         last_time_ff        <= '0;
         gain_fwd_pos_ff     <= RST_GAIN_FWD_POS;
         gain_fwd_neg_ff     <= RST_GAIN_FWD_NEG;
         gain_creep_back_ff  <= RST_GAIN_CREEP_BACK;
         gain_fwd_outside_ff <= RST_GAIN_FWD_OUTSIDE;
         fwd_band_low_ff     <= RST_FWD_BAND_LOW;
         fwd_band_high_ff    <= RST_FWD_BAND_HIGH;
         lat_band_low_ff     <= RST_LAT_BAND_LOW;
         lat_band_high_ff    <= RST_LAT_BAND_HIGH;
      end else begin
         state_ff            <= state_in;
         rsp_valid_ff        <= rsp_valid_in;
         x_accum_ff          <= x_accum_in;
         y_accum_ff          <= y_accum_in;
         yaw_ref_ff          <= yaw_ref_in;
         ref_pending_ff      <= ref_pending_in;
         last_time_ff        <= last_time_in;
         gain_fwd_pos_ff     <= gain_fwd_pos_in;
         gain_fwd_neg_ff     <= gain_fwd_neg_in;
         gain_creep_back_ff  <= gain_creep_back_in;
         gain_fwd_outside_ff <= gain_fwd_outside_in;
         fwd_band_low_ff     <= fwd_band_low_in;
         fwd_band_high_ff    <= fwd_band_high_in;
         lat_band_low_ff     <= lat_band_low_in;
         lat_band_high_ff    <= lat_band_high_in;
      end
   end

   // payload and working registers, no reset
   always_ff @(posedge clock) begin
      iter_ff        <= iter_in;
      div_cnt_ff     <= div_cnt_in;
      rsp_payload_ff <= rsp_payload_in;
      vf_ff          <= vf_in;
      vlg_ff         <= vlg_in;
      vfc_ff         <= vfc_in;
      heading_ff     <= heading_in;
      gain_ff        <= gain_in;
      dt_ff          <= dt_in;
      ang_ff         <= ang_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      flip_ff        <= flip_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      wx_ff          <= wx_in;
      wy_ff          <= wy_in;
      lane_x_ff      <= lane_x_in;
      lane_y_ff      <= lane_y_in;
   end

   // an accepted beat always starts the gain pass
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_GAIN)
      else $error("accepted beat did not start the sequencer");

   // the cordic counter stays inside the atan table
   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORDIC |-> iter_ff <= ITER_LAST)
      else $error("cordic iteration counter out of range");

   // divider remainders stay below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |->
         ({2'b0, lane_x_ff.rem} < DIV_D1) && ({2'b0, lane_y_ff.rem} < DIV_D1))
      else $error("divider remainder not below divisor");

   // the heading reference latches only to a nonzero yaw
   a_ref_nonzero: assert property (@(posedge clock) disable iff (reset)
      $fell(ref_pending_ff) |-> yaw_ref_ff != 16'sd0)
      else $error("heading reference latched to zero");

   // a rsp beat appears only from the hand-off state
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PUT)
      else $error("rsp beat raised outside the hand-off state");

endmodule

`default_nettype wire
